>>> rtl/core/pmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared constants and types for the partitioned murmur index block.
// ----------------------------------------------------------------------------
package pmi_pkg;

    localparam int MAX_FUNCTIONS   = 4;
    localparam int DEF_FUNCTIONS   = 4;
    localparam int FN_W            = 2;
    localparam int KEY_W           = 64;
    localparam int WORD_W          = 32;
    localparam int SIZE_W          = 31;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_SEED_ZERO  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_ONE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_TWO   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_THREE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TABLE_SIZE = 3'd4;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 31'd1024;

    localparam logic [WORD_W-1:0] MUR_C1 = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MUR_C2 = 32'h1b873593;
    localparam logic [WORD_W-1:0] MUR_N  = 32'he6546b64;
    localparam logic [WORD_W-1:0] MUR_F1 = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] MUR_F2 = 32'hc2b2ae35;
    localparam logic [WORD_W-1:0] MUR_LEN = 32'd4;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SIZE_W-1:0] size_t;

endpackage

>>> rtl/core/pmi_rem_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmi_rem_pipe
// Restoring remainder pipeline, one dividend bit per stage, then offset add.
// ----------------------------------------------------------------------------
module pmi_rem_pipe (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  pmi_pkg::word_t    in_dividend,
    input  pmi_pkg::size_t    in_divisor,
    input  pmi_pkg::size_t    in_offset,
    input  logic              in_invalid,
    output logic              out_valid,
    output pmi_pkg::size_t    out_index,
    output logic              out_invalid
);
    import pmi_pkg::*;

    localparam int STAGES = WORD_W;

    logic  [STAGES-1:0] valid_reg;
    word_t              rem_reg  [STAGES];
    word_t              dvd_reg  [STAGES];
    size_t              dvs_reg  [STAGES];
    size_t              off_reg  [STAGES];
    logic  [STAGES-1:0] inv_reg;
    word_t              rem_next [STAGES];
    word_t              dvd_next [STAGES];

    always_comb begin
        for (int i = 0; i < STAGES; i++) begin
            logic [WORD_W:0] trial;
            word_t           r_in;
            word_t           d_in;
            size_t           v_in;
            r_in = (i == 0) ? '0 : rem_reg[(i == 0) ? 0 : i-1];
            d_in = (i == 0) ? in_dividend : dvd_reg[(i == 0) ? 0 : i-1];
            v_in = (i == 0) ? in_divisor : dvs_reg[(i == 0) ? 0 : i-1];
            trial = {r_in, d_in[WORD_W-1]};
            if (trial >= {2'b00, v_in}) begin
                trial = trial - {2'b00, v_in};
            end
            rem_next[i] = trial[WORD_W-1:0];
            dvd_next[i] = {d_in[WORD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < STAGES; i++) begin
                rem_reg[i] <= rem_next[i];
                dvd_reg[i] <= dvd_next[i];
                dvs_reg[i] <= (i == 0) ? in_divisor : dvs_reg[(i == 0) ? 0 : i-1];
                off_reg[i] <= (i == 0) ? in_offset  : off_reg[(i == 0) ? 0 : i-1];
                inv_reg[i] <= (i == 0) ? in_invalid : inv_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // empty slice: drop the remainder term
    assign out_valid   = valid_reg[STAGES-1];
    assign out_invalid = inv_reg[STAGES-1];
    assign out_index   = inv_reg[STAGES-1] ? '0
                       : (dvs_reg[STAGES-1] == '0) ? off_reg[STAGES-1]
                       : off_reg[STAGES-1] + rem_reg[STAGES-1][SIZE_W-1:0];

endmodule

>>> rtl/core/partitioned_murmur_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partitioned_murmur_index
// Murmur3 x86_32 hash of the key's low word, XORed with its high word, mapped into one function's table slice.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_        in         tuser: function_number; tdata: key_value
//  m_        out        tuser: index_invalid; tdata: table_index
//  cfg_      in         seed_zero..seed_three, table_size (index 0..4)
//
//  One request per cycle unless a stalled output holds it; the path is 6 hash stages + 32 remainder
//  stages + 1 output register, the remainder chain resolving one bit per stage.
//  aresetn is synchronous; seeds return to 0..3 and table size to 1024.
//  A stalled output freezes the whole pipeline; nothing is lost or repeated.
module partitioned_murmur_index #(
    parameter int NUM_FUNCTIONS = pmi_pkg::DEF_FUNCTIONS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pmi_pkg::KEY_W-1:0]          s_tdata,   // [63:0] key_value
    input  logic [pmi_pkg::FN_W-1:0]           s_tuser,   // [1:0] function_number
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pmi_pkg::WORD_W-1:0]         m_tdata,   // [30:0] table_index, [31] zero
    output logic                               m_tuser,   // [0] index_invalid
    input  logic                               cfg_wr_en,
    input  logic [pmi_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pmi_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pmi_pkg::*;

    localparam int             SHIFT_N = $clog2(NUM_FUNCTIONS);
    localparam logic [32:0]    RECIP3  = 33'((64'd1 << 33) / 3 + 1);
    localparam logic [SIZE_W-1:0] LAST_MUL = SIZE_W'(NUM_FUNCTIONS - 1);

    word_t seed_reg [MAX_FUNCTIONS];
    size_t table_size_reg;
    size_t slice_reg;
    size_t domain_reg [MAX_FUNCTIONS];
    size_t offset_reg [MAX_FUNCTIONS];

    logic  en;
    logic  rem_valid;
    size_t rem_index;
    logic  rem_invalid;
    logic  m_tvalid_reg;
    size_t m_index_reg;
    logic  m_invalid_reg;

    logic  [5:0]      v_reg;
    logic  [FN_W-1:0] fn_reg  [6];
    logic             inv_reg [6];
    word_t            hi_reg  [6];
    word_t            h1_reg, h2_reg, h3_reg, h4_reg, h5_reg, h6_reg;
    word_t            h1_next, h2_next, h3_next, h4_next, h5_next, h6_next;
    size_t            slice_next;

    function automatic word_t rotl(input word_t v, input int r);
        return (v << r) | (v >> (WORD_W - r));
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_FUNCTIONS; i++) begin
                seed_reg[i] <= WORD_W'(i);
            end
            table_size_reg <= TABLE_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SEED_ZERO:  seed_reg[0]    <= cfg_wdata;
                REG_SEED_ONE:   seed_reg[1]    <= cfg_wdata;
                REG_SEED_TWO:   seed_reg[2]    <= cfg_wdata;
                REG_SEED_THREE: seed_reg[3]    <= cfg_wdata;
                REG_TABLE_SIZE: table_size_reg <= cfg_wdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    generate
        if (NUM_FUNCTIONS == 3) begin : g_div3
            logic [63:0] prod;
            assign prod       = {33'd0, table_size_reg} * {31'd0, RECIP3};
            assign slice_next = prod[33 +: SIZE_W];
        end else begin : g_shift
            assign slice_next = table_size_reg >> SHIFT_N;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        slice_reg <= slice_next;
        for (int i = 0; i < MAX_FUNCTIONS; i++) begin
            offset_reg[i] <= SIZE_W'(slice_reg * SIZE_W'(i));
            domain_reg[i] <= (i == NUM_FUNCTIONS - 1)
                           ? table_size_reg - SIZE_W'(slice_reg * LAST_MUL)
                           : slice_reg;
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        word_t t;
        h1_next = s_tdata[WORD_W-1:0] * MUR_C1;
        h2_next = rotl(h1_reg, 15) * MUR_C2;
        t = seed_reg[fn_reg[1]] ^ h2_reg;
        t = rotl(t, 13);
        t = (t << 2) + t + MUR_N;
        t = t ^ MUR_LEN;
        h3_next = t ^ (t >> 16);
        h4_next = h3_reg * MUR_F1;
        t = h4_reg ^ (h4_reg >> 13);
        h5_next = t * MUR_F2;
        h6_next = h5_reg ^ (h5_reg >> 16) ^ hi_reg[4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fn_reg[0]  <= s_tuser;
            inv_reg[0] <= {1'b0, s_tuser} >= 3'(NUM_FUNCTIONS);
            hi_reg[0]  <= s_tdata[KEY_W-1:WORD_W];
            for (int i = 1; i < 6; i++) begin
                fn_reg[i]  <= fn_reg[i-1];
                inv_reg[i] <= inv_reg[i-1];
                hi_reg[i]  <= hi_reg[i-1];
            end
            h1_reg <= h1_next;
            h2_reg <= h2_next;
            h3_reg <= h3_next;
            h4_reg <= h4_next;
            h5_reg <= h5_next;
            h6_reg <= h6_next;
        end
    end

    pmi_rem_pipe u_rem (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (v_reg[5]),
        .in_dividend (h6_reg),
        .in_divisor  (domain_reg[fn_reg[5]]),
        .in_offset   (offset_reg[fn_reg[5]]),
        .in_invalid  (inv_reg[5]),
        .out_valid   (rem_valid),
        .out_index   (rem_index),
        .out_invalid (rem_invalid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= rem_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_index_reg   <= rem_index;
            m_invalid_reg <= rem_invalid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_index_reg};
    assign m_tuser  = m_invalid_reg;

endmodule
